/* src/lcc_pkg.sv */
// Shared types and byte constants for the lexical context classifier.
`timescale 1ns / 1ps

package lcc_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CTX_W  = 2;
  localparam int unsigned RUN_W  = 2;

  // Characters the lexer reacts to
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_DQUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_SQUOTE  = 8'h27;
  localparam logic [BYTE_W-1:0] CH_STAR    = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_SLASH   = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_BSLASH  = 8'h5C;

  // Quotes in a row that close a heredoc
  localparam logic [RUN_W-1:0] HEREDOC_CLOSE_RUN = 2'd3;

  typedef enum logic [CTX_W-1:0] {
    CTX_CODE    = 2'd0,
    CTX_COMMENT = 2'd1,
    CTX_STRING  = 2'd2
  } ctx_t;

  typedef enum logic [8:0] {
    M_CODE       = 9'b000000001,
    M_SLASH      = 9'b000000010,
    M_LINE       = 9'b000000100,
    M_BLOCK      = 9'b000001000,
    M_BLOCK_STAR = 9'b000010000,
    M_DQ_ONE     = 9'b000100000,
    M_DQ_TWO     = 9'b001000000,
    M_QUOTED     = 9'b010000000,
    M_HEREDOC    = 9'b100000000
  } lex_mode_t;

  typedef struct packed {
    lex_mode_t        lex_mode;
    logic             closing_is_single_quote;
    logic             escape_pending;
    logic [RUN_W-1:0] heredoc_quote_run;
  } lex_state_t;

  localparam lex_state_t LEX_STATE_RESET = '{
    lex_mode:                M_CODE,
    closing_is_single_quote: 1'b0,
    escape_pending:          1'b0,
    heredoc_quote_run:       '0
  };

endpackage

/* src/lexical_context_classifier.sv */
// Top level of the lexical context classifier for C-style source text.
`timescale 1ns / 1ps

// Classifies source text one byte per transaction: for every byte taken on
// the slave stream, one result on the master stream says whether the cursor
// position just before that byte lies in code (0), a comment (1) or a string
// literal (2). Line comments, non-nesting block comments, single- and
// double-quoted strings with backslash escapes, and triple-quote heredocs are
// recognised. A transaction with s_tlast set carries no byte: it returns the
// context at the end of the file and then clears the lexer for the next file.
// One byte is taken every clock cycle while the output buffer has room; the
// figure is set by the lexer state register, which is read and rewritten in
// the same cycle. Results are registered in a two-entry output buffer that
// lets input go on for one more transaction while the master side stalls.

module lexical_context_classifier import lcc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  // Source byte stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  input  logic       s_tlast,   // end_of_text
  // Context result stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [1:0] context_here, [7:2] zero
);

  lex_state_t lex_state;
  lex_state_t lex_state_next;
  ctx_t       step_ctx;
  ctx_t       out_ctx;
  logic       s_fire;

  assign s_fire = s_tvalid && s_tready;

  lcc_step u_step (
    .state        (lex_state),
    .text_byte    (s_tdata[BYTE_W-1:0]),
    .end_of_text  (s_tlast),
    .state_next   (lex_state_next),
    .context_here (step_ctx)
  );

  // Advance the lexer only on an accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      lex_state <= LEX_STATE_RESET;
    end else if (s_fire) begin
      lex_state <= lex_state_next;
    end
  end

  lcc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_ctx    (step_ctx),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_ctx   (out_ctx)
  );

  // Pad the context code up to a whole byte
  assign m_tdata = {(8 - CTX_W)'(0), out_ctx};

endmodule

/* src/lcc_step.sv */
// Next-state and context decision for one source byte.
`timescale 1ns / 1ps

module lcc_step import lcc_pkg::*; (
  input  lex_state_t        state,
  input  logic [BYTE_W-1:0] text_byte,
  input  logic              end_of_text,
  output lex_state_t        state_next,
  output ctx_t              context_here
);

  function automatic lex_state_t code_byte(input lex_state_t s, input logic [BYTE_W-1:0] b);
    lex_state_t r;
    r = s;
    if (b == CH_SLASH) begin
      r.lex_mode = M_SLASH;
    end else if (b == CH_DQUOTE) begin
      r.lex_mode = M_DQ_ONE;
      r.closing_is_single_quote = 1'b0;
      r.escape_pending = 1'b0;
    end else if (b == CH_SQUOTE) begin
      r.lex_mode = M_QUOTED;
      r.closing_is_single_quote = 1'b1;
      r.escape_pending = 1'b0;
    end else begin
      r.lex_mode = M_CODE;
    end
    return r;
  endfunction

  function automatic lex_state_t quoted_byte(input lex_state_t s, input logic [BYTE_W-1:0] b);
    lex_state_t        r;
    logic [BYTE_W-1:0] closer;
    r = s;
    closer = s.closing_is_single_quote ? CH_SQUOTE : CH_DQUOTE;
    if (b == CH_NEWLINE) begin
      r.lex_mode = M_CODE;
      r.escape_pending = 1'b0;
    end else if (s.escape_pending) begin
      r.escape_pending = 1'b0;
      r.lex_mode = M_QUOTED;
    end else if (b == closer) begin
      r.lex_mode = M_CODE;
    end else begin
      r.escape_pending = (b == CH_BSLASH);
      r.lex_mode = M_QUOTED;
    end
    return r;
  endfunction

  always_comb begin
    lex_state_t       s;
    logic [RUN_W-1:0] run_inc;
    s = state;
    state_next = state;
    context_here = CTX_CODE;
    run_inc = state.heredoc_quote_run + RUN_W'(1);

    if (end_of_text) begin
      // Report the end position, then drop back to reset
      state_next = LEX_STATE_RESET;
      case (state.lex_mode)
        M_LINE, M_BLOCK, M_BLOCK_STAR: context_here = CTX_COMMENT;
        M_DQ_ONE, M_QUOTED, M_HEREDOC: context_here = CTX_STRING;
        default:                       context_here = CTX_CODE;
      endcase
    end else begin
      case (state.lex_mode)
        M_SLASH: begin
          if (text_byte == CH_SLASH) begin
            context_here = CTX_COMMENT;
            state_next.lex_mode = M_LINE;
          end else if (text_byte == CH_STAR) begin
            context_here = CTX_COMMENT;
            state_next.lex_mode = M_BLOCK;
          end else begin
            state_next = code_byte(state, text_byte);
          end
        end
        M_LINE: begin
          context_here = CTX_COMMENT;
          if (text_byte == CH_NEWLINE) state_next.lex_mode = M_CODE;
        end
        M_BLOCK, M_BLOCK_STAR: begin
          context_here = CTX_COMMENT;
          if (state.lex_mode == M_BLOCK_STAR && text_byte == CH_SLASH) begin
            state_next.lex_mode = M_CODE;
          end else begin
            state_next.lex_mode = (text_byte == CH_STAR) ? M_BLOCK_STAR : M_BLOCK;
          end
        end
        M_DQ_ONE: begin
          context_here = CTX_STRING;
          if (text_byte == CH_DQUOTE) begin
            state_next.lex_mode = M_DQ_TWO;
          end else begin
            s.closing_is_single_quote = 1'b0;
            s.escape_pending = 1'b0;
            state_next = quoted_byte(s, text_byte);
          end
        end
        M_DQ_TWO: begin
          if (text_byte == CH_DQUOTE) begin
            context_here = CTX_STRING;
            state_next.lex_mode = M_HEREDOC;
            state_next.heredoc_quote_run = '0;
          end else begin
            state_next = code_byte(state, text_byte);
          end
        end
        M_QUOTED: begin
          context_here = CTX_STRING;
          state_next = quoted_byte(state, text_byte);
        end
        M_HEREDOC: begin
          context_here = CTX_STRING;
          if (text_byte == CH_DQUOTE) begin
            if (run_inc == HEREDOC_CLOSE_RUN) begin
              state_next.heredoc_quote_run = '0;
              state_next.lex_mode = M_CODE;
            end else begin
              state_next.heredoc_quote_run = run_inc;
            end
          end else begin
            state_next.heredoc_quote_run = '0;
          end
        end
        default: begin
          state_next = code_byte(state, text_byte);
        end
      endcase
    end
  end

endmodule

/* src/lcc_out_buf.sv */
// Two-entry output register with skid stage for the context results.
`timescale 1ns / 1ps

module lcc_out_buf import lcc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  ctx_t in_ctx,
  output logic out_valid,
  input  logic out_ready,
  output ctx_t out_ctx
);

  logic skid_valid;
  ctx_t skid_ctx;
  logic out_fire;
  logic in_fire;

  assign in_ready = !skid_valid;
  assign out_fire = out_valid && out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_fire) begin
      if (skid_valid) begin
        // Advance the skid entry; no input can arrive while it is full
        skid_valid <= 1'b0;
      end else if (!in_fire) begin
        out_valid <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      if (skid_valid) begin
        out_ctx <= skid_ctx;
      end else if (in_fire) begin
        out_ctx <= in_ctx;
      end
    end else if (in_fire) begin
      if (!out_valid) begin
        out_ctx <= in_ctx;
      end else begin
        skid_ctx <= in_ctx;
      end
    end
  end

endmodule

/* src/lcc_checker.sv */
// Port-level checks for the lexical context classifier, bound to the top level.
`timescale 1ns / 1ps

module lcc_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // A stalled result holds its value
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Only the three context codes appear, upper bits zero
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] != 2'd3) && (m_tdata[7:2] == 6'd0))
    else $error("bad context code");

  // Input back-pressure only while a result is waiting
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output");

  // After an accepted transaction a result is valid in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("result missing after accepted transaction");

  // Reset empties the output
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind lexical_context_classifier lcc_checker u_lcc_checker (.*);
